// ===== rtl/core/mct_pkg.sv =====
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and constants for the mesh convexity test block.
// ----------------------------------------------------------------------------
package mct_pkg;

	localparam int NORMAL_W  = 16;
	localparam int FACE_W    = 12;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 3;

	localparam logic [FACE_W-1:0] FACE_LIMIT = 12'd4095;
	localparam logic [FACE_W-1:0] MIN_FACES  = 12'd4;

	localparam logic OP_VERTEX = 1'b0;
	localparam logic OP_FACE   = 1'b1;

	localparam logic REG_EPSILON = 1'b0;
	localparam logic [DATA_W-1:0] EPSILON_RESET = 32'd16;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

endpackage

// ===== rtl/core/mct_item_if.sv =====
// ----------------------------------------------------------------------------
// mct_item_if
// Input channel: vertex and face items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mct_item_if #(
	parameter int COORD_BITS = 24
);
	import mct_pkg::*;

	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic signed [COORD_BITS-1:0]  pos_x;
	logic signed [COORD_BITS-1:0]  pos_y;
	logic signed [COORD_BITS-1:0]  pos_z;
	logic signed [NORMAL_W-1:0]    normal_x;
	logic signed [NORMAL_W-1:0]    normal_y;
	logic signed [NORMAL_W-1:0]    normal_z;
	logic                          last_face;

	modport source (
		output valid, opcode, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, last_face,
		input  ready
	);

	modport sink (
		input  valid, opcode, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, last_face,
		output ready
	);

endinterface

// ===== rtl/core/mct_result_if.sv =====
// ----------------------------------------------------------------------------
// mct_result_if
// Output channel: one verdict beat per mesh with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mct_result_if;
	import mct_pkg::*;

	logic              valid;
	logic              ready;
	logic              convex;
	logic [FACE_W-1:0] faces_seen;
	logic              vertex_overflow;

	modport source (
		output valid, convex, faces_seen, vertex_overflow,
		input  ready
	);

	modport sink (
		input  valid, convex, faces_seen, vertex_overflow,
		output ready
	);

endinterface

// ===== rtl/core/mesh_convexity_test.sv =====
// ----------------------------------------------------------------------------
// mesh_convexity_test
// Checks a polyhedral mesh for convexity against the plane of every face.
// ----------------------------------------------------------------------------
// Vertex items are written into the vertex memory; vertices beyond
// MAX_VERTICES are dropped and flagged. A face item scans the stored
// vertices through the single read port of that memory, one vertex per cycle,
// into a four-stage dot product pipeline; a face skips the scan when the
// store is empty. The face marked last produces one verdict beat, held in an
// output register, and clears the mesh state; new items are taken while that
// beat waits.
module mesh_convexity_test #(
	parameter int MAX_VERTICES = 256,
	parameter int COORD_BITS   = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mct_item_if.sink                       items,
	mct_result_if.source                   verdict,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mct_pkg::ADDR_W-1:0]     paddr,
	input  logic [mct_pkg::DATA_W-1:0]     pwdata,
	output logic [mct_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);
	import mct_pkg::*;

	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);
	localparam int DW   = COORD_BITS + 1;
	localparam int PW   = DW + NORMAL_W;
	localparam int SW   = PW + 2;
	localparam int CW   = (SW > DATA_W + 2) ? SW : DATA_W + 2;
	localparam int VW   = 3 * COORD_BITS;

	state_t state_q;

	logic [DATA_W-1:0] eps_q;
	logic [CNTW-1:0]   vcount_q;
	logic [CNTW-1:0]   k_q;
	logic [FACE_W-1:0] face_cnt_q;
	logic              verdict_q;
	logic              overflow_q;
	logic              pos_q;
	logic              neg_q;

	logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
	logic signed [NORMAL_W-1:0]   nx_q, ny_q, nz_q;
	logic                         last_q;

	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [DW-1:0]  dx_s2, dy_s2, dz_s2;
	logic signed [PW-1:0]  mx_s3, my_s3, mz_s3;
	logic signed [SW-1:0]  dot_s4;

	logic                 out_vld_q;
	logic                 out_convex_q;
	logic [FACE_W-1:0]    out_faces_q;
	logic                 out_ovf_q;

	logic accept;
	logic ram_we;
	logic ram_re;
	logic [VW-1:0] ram_rdata;
	logic signed [COORD_BITS-1:0] vx, vy, vz;
	logic signed [CW-1:0] dot_c, eps_c;
	logic pipe_busy;
	logic fin_go;
	logic out_load;
	logic verdict_new;
	logic [FACE_W-1:0] face_new;
	logic cfg_we;

	assign items.ready = (state_q == ST_IDLE);
	assign accept      = items.valid && items.ready;
	assign ram_we      = accept && (items.opcode == OP_VERTEX) &&
	                     (vcount_q < CNTW'(MAX_VERTICES));
	assign ram_re      = (state_q == ST_SCAN);

	mct_ram #(
		.WIDTH (VW),
		.DEPTH (MAX_VERTICES)
	) u_vertex_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (vcount_q[AW-1:0]),
		.wdata ({items.pos_x, items.pos_y, items.pos_z}),
		.re    (ram_re),
		.raddr (k_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign vx = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
	assign vy = ram_rdata[2*COORD_BITS-1:COORD_BITS];
	assign vz = ram_rdata[COORD_BITS-1:0];

	assign dot_c = CW'(dot_s4);
	assign eps_c = $signed(CW'(eps_q));

	assign pipe_busy   = vld_s1 || vld_s2 || vld_s3 || vld_s4;
	assign fin_go      = !last_q || !out_vld_q || verdict.ready;
	assign out_load    = (state_q == ST_FINISH) && last_q && fin_go;
	assign verdict_new = verdict_q && !(pos_q && neg_q);
	assign face_new    = (face_cnt_q < FACE_LIMIT) ? face_cnt_q + FACE_W'(1) : face_cnt_q;

	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_EPSILON);
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_EPSILON) ? eps_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPSILON_RESET;
		end else if (cfg_we) begin
			eps_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vcount_q   <= '0;
			k_q        <= '0;
			face_cnt_q <= '0;
			verdict_q  <= 1'b1;
			overflow_q <= 1'b0;
			pos_q      <= 1'b0;
			neg_q      <= 1'b0;
		end else begin
			if (vld_s4) begin
				if (dot_c > eps_c) begin
					pos_q <= 1'b1;
				end else if (dot_c < -eps_c) begin
					neg_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && items.opcode == OP_VERTEX) begin
						if (ram_we) begin
							vcount_q <= vcount_q + CNTW'(1);
						end else begin
							overflow_q <= 1'b1;
						end
					end else if (accept) begin
						pos_q <= 1'b0;
						neg_q <= 1'b0;
						k_q   <= '0;
						state_q <= (vcount_q == '0) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					k_q <= k_q + CNTW'(1);
					if (k_q + CNTW'(1) == vcount_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							vcount_q   <= '0;
							face_cnt_q <= '0;
							verdict_q  <= 1'b1;
							overflow_q <= 1'b0;
						end else begin
							face_cnt_q <= face_new;
							verdict_q  <= verdict_new;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && items.opcode == OP_FACE) begin
			px_q   <= items.pos_x;
			py_q   <= items.pos_y;
			pz_q   <= items.pos_z;
			nx_q   <= items.normal_x;
			ny_q   <= items.normal_y;
			nz_q   <= items.normal_z;
			last_q <= items.last_face;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= ram_re;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= DW'(vx) - DW'(px_q);
		dy_s2  <= DW'(vy) - DW'(py_q);
		dz_s2  <= DW'(vz) - DW'(pz_q);
		mx_s3  <= PW'(nx_q) * PW'(dx_s2);
		my_s3  <= PW'(ny_q) * PW'(dy_s2);
		mz_s3  <= PW'(nz_q) * PW'(dz_s2);
		dot_s4 <= SW'(mx_s3) + SW'(my_s3) + SW'(mz_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (verdict.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_convex_q <= verdict_new && (face_new >= MIN_FACES);
			out_faces_q  <= face_new;
			out_ovf_q    <= overflow_q;
		end
	end

	assign verdict.valid           = out_vld_q;
	assign verdict.convex          = out_convex_q;
	assign verdict.faces_seen      = out_faces_q;
	assign verdict.vertex_overflow = out_ovf_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> k_q < vcount_q)
		else $error("Scan index ran past the stored vertex count.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= CNTW'(MAX_VERTICES))
		else $error("Vertex count exceeds the store capacity.");

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pipe_busy)
		else $error("Dot product pipeline busy while idle.");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> vcount_q == '0 && face_cnt_q == '0 && verdict_q && out_vld_q)
		else $error("Mesh state not cleared after a verdict beat.");

endmodule

// ===== rtl/core/mct_ram.sv =====
// ----------------------------------------------------------------------------
// mct_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mct_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== verif/tb_mesh_convexity_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh_convexity_test
// Self-checking testbench for the mesh convexity test block.
// ----------------------------------------------------------------------------
// Vertex and face beats are driven with random gaps, and verdict beats are
// taken with random stalls. A mesh state tracker in the testbench computes the
// expected verdict of every mesh, and each verdict beat is compared field by
// field with the oldest pending one. The tests cover extreme coordinates and
// normals, several dead band settings over the register port, a full vertex
// memory, a long output stall, and random box-shaped and unstructured meshes.
// ----------------------------------------------------------------------------
module tb_mesh_convexity_test;
	import mct_pkg::*;

	localparam int MAX_VERTS     = 256;
	localparam int COORD_W       = 24;
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_ITEMS  = 560;
	localparam int CMAX          = 8388607;
	localparam int CMIN          = -8388608;
	localparam int NMAX          = 32767;
	localparam int NMIN          = -32768;
	localparam logic [ADDR_W-1:0] EPSILON_ADDR = ADDR_W'(4 * REG_EPSILON);

	typedef struct {
		logic                        opcode;
		logic signed [COORD_W-1:0]   pos_x;
		logic signed [COORD_W-1:0]   pos_y;
		logic signed [COORD_W-1:0]   pos_z;
		logic signed [NORMAL_W-1:0]  normal_x;
		logic signed [NORMAL_W-1:0]  normal_y;
		logic signed [NORMAL_W-1:0]  normal_z;
		logic                        last_face;
	} mesh_item_t;

	typedef struct {
		logic              convex;
		logic [FACE_W-1:0] faces_seen;
		logic              vertex_overflow;
	} verdict_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	mct_item_if #(.COORD_BITS(COORD_W)) item_ch ();
	mct_result_if verdict_ch ();

	mesh_convexity_test #(
		.MAX_VERTICES(MAX_VERTS),
		.COORD_BITS(COORD_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.items(item_ch),
		.verdict(verdict_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic signed [COORD_W-1:0] vert_x [MAX_VERTS];
	logic signed [COORD_W-1:0] vert_y [MAX_VERTS];
	logic signed [COORD_W-1:0] vert_z [MAX_VERTS];
	int unsigned               vert_count;
	bit                        convex_so_far;
	logic [FACE_W-1:0]         face_total;
	bit                        dropped_vertex;
	logic [DATA_W-1:0]         epsilon_value;

	verdict_t    verdicts_due [$];
	int          mismatches;
	int unsigned items_sent;
	bit          steady;
	int unsigned hold_request;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		return steady ? 0 : int'($urandom_range(0, 7));
	endfunction

	function automatic mesh_item_t mk(input logic op, input int x, input int y, input int z,
			input int nx, input int ny, input int nz, input logic last);
		mesh_item_t it;
		it.opcode    = op;
		it.pos_x     = x[COORD_W-1:0];
		it.pos_y     = y[COORD_W-1:0];
		it.pos_z     = z[COORD_W-1:0];
		it.normal_x  = nx[NORMAL_W-1:0];
		it.normal_y  = ny[NORMAL_W-1:0];
		it.normal_z  = nz[NORMAL_W-1:0];
		it.last_face = last;
		return it;
	endfunction

	// Tracks the mesh in progress; a face beat checks every stored vertex
	// against its plane and the last face closes the mesh with a verdict.
	function automatic void update_mesh_state(input mesh_item_t it);
		longint   dot;
		longint   band;
		bit       seen_pos;
		bit       seen_neg;
		verdict_t v;
		band     = longint'(epsilon_value);
		seen_pos = 1'b0;
		seen_neg = 1'b0;
		if (it.opcode == OP_VERTEX) begin
			if (vert_count < MAX_VERTS) begin
				vert_x[vert_count] = it.pos_x;
				vert_y[vert_count] = it.pos_y;
				vert_z[vert_count] = it.pos_z;
				vert_count++;
			end else begin
				dropped_vertex = 1'b1;
			end
		end else begin
			for (int k = 0; k < vert_count; k++) begin
				dot = longint'(it.normal_x) * (longint'(vert_x[k]) - longint'(it.pos_x))
					+ longint'(it.normal_y) * (longint'(vert_y[k]) - longint'(it.pos_y))
					+ longint'(it.normal_z) * (longint'(vert_z[k]) - longint'(it.pos_z));
				if (dot > band) begin
					seen_pos = 1'b1;
				end else if (dot < -band) begin
					seen_neg = 1'b1;
				end
			end
			if (seen_pos && seen_neg) begin
				convex_so_far = 1'b0;
			end
			if (face_total != FACE_LIMIT) begin
				face_total++;
			end
			if (it.last_face) begin
				v.convex          = convex_so_far && (face_total >= MIN_FACES);
				v.faces_seen      = face_total;
				v.vertex_overflow = dropped_vertex;
				verdicts_due.push_back(v);
				vert_count     = 0;
				convex_so_far  = 1'b1;
				face_total     = '0;
				dropped_vertex = 1'b0;
			end
		end
	endfunction

	always @(posedge clk) begin
		mesh_item_t seen;
		verdict_t   due;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				seen.opcode    = item_ch.opcode;
				seen.pos_x     = item_ch.pos_x;
				seen.pos_y     = item_ch.pos_y;
				seen.pos_z     = item_ch.pos_z;
				seen.normal_x  = item_ch.normal_x;
				seen.normal_y  = item_ch.normal_y;
				seen.normal_z  = item_ch.normal_z;
				seen.last_face = item_ch.last_face;
				update_mesh_state(seen);
			end
			if (verdict_ch.valid && verdict_ch.ready) begin
				if (verdicts_due.size() == 0) begin
					$error("verdict beat arrived with no verdict pending");
					mismatches++;
				end else begin
					due = verdicts_due.pop_front();
					if (verdict_ch.convex !== due.convex) begin
						$error("convex expected %0b actual %0b",
							due.convex, verdict_ch.convex);
						mismatches++;
					end
					if (verdict_ch.faces_seen !== due.faces_seen) begin
						$error("faces_seen expected %0d actual %0d",
							due.faces_seen, verdict_ch.faces_seen);
						mismatches++;
					end
					if (verdict_ch.vertex_overflow !== due.vertex_overflow) begin
						$error("vertex_overflow expected %0b actual %0b",
							due.vertex_overflow, verdict_ch.vertex_overflow);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin : verdict_sink
		int          stall;
		int unsigned held;
		verdict_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request != 0) begin
				held = hold_request;
				hold_request = 0;
				verdict_ch.ready <= 1'b0;
				repeat (held) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					verdict_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			verdict_ch.ready <= 1'b1;
			forever begin
				@(posedge clk);
				if ((verdict_ch.valid && verdict_ch.ready) || hold_request != 0) begin
					break;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_item(input mesh_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.opcode    <= it.opcode;
		item_ch.pos_x     <= it.pos_x;
		item_ch.pos_y     <= it.pos_y;
		item_ch.pos_z     <= it.pos_z;
		item_ch.normal_x  <= it.normal_x;
		item_ch.normal_y  <= it.normal_y;
		item_ch.normal_z  <= it.normal_z;
		item_ch.last_face <= it.last_face;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	// Faces without the last mark give no verdict, so a scan may still be
	// running when the queue empties; the extra wait covers a full scan.
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_epsilon(input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= EPSILON_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		epsilon_value = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== epsilon_value) begin
			$error("epsilon readback expected %0d actual %0d", epsilon_value, prdata);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// An axis-aligned box: eight corners, a few inner points and up to six
	// faces whose planes hold four corners each. A spoiled box gets one point
	// outside the +x face, which splits the vertices of that face.
	task automatic send_box_mesh(input bit spoil, input int faces_used);
		int ctr [3];
		int half [3];
		int nrm [3];
		int ref_pt [3];
		int inner;
		int axis;
		int mag;
		for (int a = 0; a < 3; a++) begin
			ctr[a] = int'($urandom_range(0, 8_000_000)) - 4_000_000;
			if ($urandom_range(0, 3) == 0) begin
				half[a] = int'($urandom_range(1, 64));
			end else begin
				half[a] = int'($urandom_range(1, 4_000_000));
			end
		end
		for (int c = 0; c < 8; c++) begin
			send_item(mk(OP_VERTEX,
				c[0] ? ctr[0] + half[0] : ctr[0] - half[0],
				c[1] ? ctr[1] + half[1] : ctr[1] - half[1],
				c[2] ? ctr[2] + half[2] : ctr[2] - half[2],
				int'($urandom), int'($urandom), int'($urandom), logic'($urandom_range(0, 1))));
		end
		inner = int'($urandom_range(0, 4));
		for (int i = 0; i < inner; i++) begin
			send_item(mk(OP_VERTEX,
				ctr[0] - half[0] + int'($urandom_range(0, 2 * half[0])),
				ctr[1] - half[1] + int'($urandom_range(0, 2 * half[1])),
				ctr[2] - half[2] + int'($urandom_range(0, 2 * half[2])),
				int'($urandom), int'($urandom), int'($urandom), 1'b0));
		end
		if (spoil) begin
			send_item(mk(OP_VERTEX, ctr[0] + half[0] + int'($urandom_range(1, 1000)),
				ctr[1], ctr[2], 0, 0, 0, 1'b0));
		end
		for (int f = 0; f < faces_used; f++) begin
			axis = f / 2;
			mag  = int'($urandom_range(1, NMAX));
			for (int a = 0; a < 3; a++) begin
				nrm[a]    = 0;
				ref_pt[a] = int'($urandom);
			end
			if (f % 2 == 0) begin
				nrm[axis]    = mag;
				ref_pt[axis] = ctr[axis] + half[axis];
			end else begin
				nrm[axis]    = ($urandom_range(0, 7) == 0) ? NMIN : -mag;
				ref_pt[axis] = ctr[axis] - half[axis];
			end
			send_item(mk(OP_FACE, ref_pt[0], ref_pt[1], ref_pt[2], nrm[0], nrm[1], nrm[2],
				f == faces_used - 1));
		end
	endtask

	task automatic send_random_mesh(input int len);
		logic op;
		for (int i = 0; i < len; i++) begin
			if (i == len - 1) begin
				op = OP_FACE;
			end else begin
				op = $urandom_range(0, 1) ? OP_FACE : OP_VERTEX;
			end
			send_item(mk(op, int'($urandom), int'($urandom), int'($urandom),
				int'($urandom), int'($urandom), int'($urandom),
				(op == OP_FACE) ? (i == len - 1) : logic'($urandom_range(0, 1))));
		end
	endtask

	task automatic test_directed_shapes();
		for (int c = 0; c < 8; c++) begin
			send_item(mk(OP_VERTEX, c[0] ? CMAX : CMIN, c[1] ? CMAX : CMIN, c[2] ? CMAX : CMIN,
				c[0] ? NMAX : NMIN, c[1] ? NMAX : NMIN, c[2] ? NMAX : NMIN, c == 3));
		end
		send_item(mk(OP_FACE, CMAX, 0, 0, NMAX, 0, 0, 1'b0));
		send_item(mk(OP_FACE, CMIN, CMAX, CMIN, NMIN, 0, 0, 1'b0));
		send_item(mk(OP_FACE, 0, CMAX, 0, 0, NMAX, 0, 1'b0));
		send_item(mk(OP_FACE, CMAX, CMIN, CMAX, 0, NMIN, 0, 1'b0));
		send_item(mk(OP_FACE, 0, 0, CMAX, 0, 0, NMAX, 1'b0));
		send_item(mk(OP_FACE, CMIN, CMIN, CMIN, 0, 0, NMIN, 1'b1));
		send_item(mk(OP_FACE, 0, 0, 0, 16384, 0, 0, 1'b1));
		send_item(mk(OP_VERTEX, -5, 0, 0, 0, 0, 0, 1'b0));
		send_item(mk(OP_VERTEX, 5, 0, 0, 0, 0, 0, 1'b0));
		send_item(mk(OP_VERTEX, 0, 3, 0, 0, 0, 0, 1'b0));
		send_item(mk(OP_FACE, 0, 0, 0, 16384, 0, 0, 1'b0));
		send_item(mk(OP_FACE, 0, 3, 0, 0, 16384, 0, 1'b0));
		send_item(mk(OP_FACE, -5, 0, 0, -16384, 0, 0, 1'b0));
		send_item(mk(OP_FACE, 0, 0, 0, 0, 0, 16384, 1'b1));
		settle();
	endtask

	task automatic test_epsilon_range();
		logic [DATA_W-1:0] bands [5];
		bands[0] = '0;
		bands[1] = 32'd1;
		bands[2] = 32'hFFFF_FFFF;
		bands[3] = $urandom;
		bands[4] = EPSILON_RESET;
		for (int b = 0; b < 5; b++) begin
			write_epsilon(bands[b]);
			send_box_mesh(1'b0, 6);
			send_box_mesh(1'b1, 6);
			send_random_mesh(int'($urandom_range(4, 10)));
			settle();
		end
	endtask

	task automatic test_vertex_overflow();
		for (int i = 0; i < MAX_VERTS + 4; i++) begin
			send_item(mk(OP_VERTEX, int'($urandom_range(0, 2000)) - 1000,
				int'($urandom_range(0, 2000)) - 1000, int'($urandom_range(0, 2000)) - 1000,
				int'($urandom), int'($urandom), int'($urandom), 1'b0));
		end
		for (int f = 0; f < 4; f++) begin
			send_item(mk(OP_FACE, int'($urandom), int'($urandom), int'($urandom),
				int'($urandom), int'($urandom), int'($urandom), f == 3));
		end
		send_box_mesh(1'b0, 6);
		settle();
	endtask

	task automatic test_output_backpressure();
		hold_request = 500;
		steady = 1'b1;
		repeat (6) send_box_mesh(1'b0, 4);
		steady = 1'b0;
		settle();
	endtask

	task automatic test_random_meshes();
		int unsigned start;
		int          kind;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 24) == 0) begin
				settle();
				case ($urandom_range(0, 3))
					0: write_epsilon('0);
					1: write_epsilon(DATA_W'($urandom_range(0, 64)));
					2: write_epsilon($urandom);
					default: write_epsilon(EPSILON_RESET);
				endcase
			end
			steady = ($urandom_range(0, 5) == 0);
			kind = int'($urandom_range(0, 9));
			if (kind < 5) begin
				send_box_mesh(1'b0, 6);
			end else if (kind < 6) begin
				send_box_mesh(1'b1, 6);
			end else if (kind < 7) begin
				send_box_mesh($urandom_range(0, 1), int'($urandom_range(3, 5)));
			end else begin
				send_random_mesh(int'($urandom_range(1, 16)));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		mismatches     = 0;
		items_sent     = 0;
		steady         = 1'b0;
		hold_request   = 0;
		vert_count     = 0;
		convex_so_far  = 1'b1;
		face_total     = '0;
		dropped_vertex = 1'b0;
		epsilon_value  = EPSILON_RESET;

		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.opcode    <= OP_VERTEX;
		item_ch.pos_x     <= '0;
		item_ch.pos_y     <= '0;
		item_ch.pos_z     <= '0;
		item_ch.normal_x  <= '0;
		item_ch.normal_y  <= '0;
		item_ch.normal_z  <= '0;
		item_ch.last_face <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_shapes();
		test_epsilon_range();
		test_vertex_overflow();
		test_output_backpressure();
		test_random_meshes();
		settle();

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/mct_pkg.sv
rtl/core/mct_item_if.sv
rtl/core/mct_result_if.sv
rtl/core/mct_ram.sv
rtl/core/mesh_convexity_test.sv
verif/tb_mesh_convexity_test.sv
